### sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// shared command codes and the fixed color width for the line pixel generator
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int unsigned COLOR_BITS = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

endpackage

### sv/lpg_queue.sv
// ----------------------------------------------------------------------------
// lpg_queue
// short register queue between the classifying front and the pixel back end
// ----------------------------------------------------------------------------
module lpg_queue #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == CntBits'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(DEPTH))
    else $error("queue count beyond depth");

  a_ptrs_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree while empty");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntBits'(1)))
    else $error("queue count did not follow push");

endmodule

### sv/lpg_front.sv
// ----------------------------------------------------------------------------
// lpg_front
// classifies incoming items and sets up line geometry for loads
// ----------------------------------------------------------------------------
module lpg_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            command_i,
  input  logic [COORD_BITS-1:0]           start_x_i,
  input  logic [COORD_BITS-1:0]           start_y_i,
  input  logic [COORD_BITS-1:0]           end_x_i,
  input  logic [COORD_BITS-1:0]           end_y_i,
  output logic                            is_load_o,
  output logic                            transposed_o,
  output logic                            minor_down_o,
  output logic [COORD_BITS-1:0]           major_pos_o,
  output logic [COORD_BITS-1:0]           major_end_o,
  output logic [COORD_BITS-1:0]           minor_pos_o,
  output logic [COORD_BITS-1:0]           major_span_o,
  output logic [COORD_BITS:0]             minor_twice_o
);

  logic [COORD_BITS-1:0] dx, dy, dminor;
  logic [COORD_BITS-1:0] a0, b0, a1, b1;
  logic                  swap_ends;
  logic [COORD_BITS-1:0] ma0, mb0, ma1, mb1;

  assign is_load_o = (command_i == lpg_pkg::CMD_LOAD);

  assign dx = (start_x_i > end_x_i) ? start_x_i - end_x_i : end_x_i - start_x_i;
  assign dy = (start_y_i > end_y_i) ? start_y_i - end_y_i : end_y_i - start_y_i;
  assign transposed_o = (dx < dy);

  assign a0 = transposed_o ? start_y_i : start_x_i;
  assign b0 = transposed_o ? start_x_i : start_y_i;
  assign a1 = transposed_o ? end_y_i   : end_x_i;
  assign b1 = transposed_o ? end_x_i   : end_y_i;

  assign swap_ends = (a0 > a1);
  assign ma0 = swap_ends ? a1 : a0;
  assign mb0 = swap_ends ? b1 : b0;
  assign ma1 = swap_ends ? a0 : a1;
  assign mb1 = swap_ends ? b0 : b1;

  assign dminor        = (mb0 > mb1) ? mb0 - mb1 : mb1 - mb0;
  assign major_pos_o   = ma0;
  assign major_end_o   = ma1;
  assign minor_pos_o   = mb0;
  assign major_span_o  = ma1 - ma0;
  assign minor_twice_o = {dminor, 1'b0};
  assign minor_down_o  = (mb1 < mb0);

endmodule

### sv/lpg_back.sv
// ----------------------------------------------------------------------------
// lpg_back
// bresenham stepper, output reg; one pixel per cycle when fed and not held
// ----------------------------------------------------------------------------
module lpg_back #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  output logic                            pop_o,
  input  logic                            is_load_i,
  input  logic                            transposed_i,
  input  logic                            minor_down_i,
  input  logic [COORD_BITS-1:0]           major_pos_i,
  input  logic [COORD_BITS-1:0]           major_end_i,
  input  logic [COORD_BITS-1:0]           minor_pos_i,
  input  logic [COORD_BITS-1:0]           major_span_i,
  input  logic [COORD_BITS:0]             minor_twice_i,
  input  logic [lpg_pkg::COLOR_BITS-1:0]  color_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS-1:0]           pixel_x_o,
  output logic [COORD_BITS-1:0]           pixel_y_o,
  output logic [lpg_pkg::COLOR_BITS-1:0]  pixel_color_o,
  output logic                            last_pixel_o
);

  localparam int unsigned ErrBits = COORD_BITS + 3;

  logic                           busy_q, busy_d;
  logic                           out_valid_q, out_valid_d;
  logic                           transposed_q;
  logic                           minor_down_q;
  logic [COORD_BITS-1:0]          major_pos_q;
  logic [COORD_BITS-1:0]          major_end_q;
  logic [COORD_BITS-1:0]          minor_pos_q;
  logic [COORD_BITS-1:0]          major_span_q;
  logic [COORD_BITS:0]            minor_twice_q;
  logic [ErrBits-1:0]             error_acc_q;
  logic [lpg_pkg::COLOR_BITS-1:0] held_color_q;
  logic [COORD_BITS-1:0]          pixel_x_q, pixel_y_q;
  logic [lpg_pkg::COLOR_BITS-1:0] pixel_color_q;
  logic                           last_pixel_q;

  logic                           out_free;
  logic                           do_load, do_step;
  logic                           at_end;
  logic [ErrBits-1:0]             err_sum, span_ext, err_next;
  logic                           minor_move;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = !empty_i && out_free;
  assign do_load  = pop_o && is_load_i;
  assign do_step  = pop_o && !is_load_i && busy_q;
  assign at_end   = (major_pos_q == major_end_q);

  assign span_ext   = ErrBits'(major_span_q);
  assign err_sum    = error_acc_q + ErrBits'(minor_twice_q);
  assign minor_move = ($signed(err_sum) > $signed(span_ext));
  assign err_next   = minor_move ? err_sum - (span_ext << 1) : err_sum;

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (do_step) begin
      out_valid_d = 1'b1;
      if (at_end) begin
        busy_d = 1'b0;
      end
    end
    if (do_load) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      transposed_q  <= transposed_i;
      minor_down_q  <= minor_down_i;
      major_pos_q   <= major_pos_i;
      major_end_q   <= major_end_i;
      minor_pos_q   <= minor_pos_i;
      major_span_q  <= major_span_i;
      minor_twice_q <= minor_twice_i;
      error_acc_q   <= '0;
      held_color_q  <= color_i;
    end else if (do_step && !at_end) begin
      major_pos_q <= major_pos_q + COORD_BITS'(1);
      error_acc_q <= err_next;
      if (minor_move) begin
        minor_pos_q <= minor_down_q ? minor_pos_q - COORD_BITS'(1)
                                    : minor_pos_q + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      pixel_x_q     <= transposed_q ? minor_pos_q : major_pos_q;
      pixel_y_q     <= transposed_q ? major_pos_q : minor_pos_q;
      pixel_color_q <= held_color_q;
      last_pixel_q  <= at_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_color_o = pixel_color_q;
  assign last_pixel_o  = last_pixel_q;

  a_major_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (major_pos_q <= major_end_q))
    else $error("major coordinate passed its end");

  a_error_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ($signed(error_acc_q) <= $signed(span_ext)))
    else $error("error term above major span");

  a_last_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && at_end) |=> !busy_q)
    else $error("busy held after last pixel");

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step |-> out_free)
    else $error("pixel produced over a held result");

endmodule

### sv/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator
// bresenham line engine: load endpoints and color, then emit one pixel per step
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_ready_o command, endpoints, line color
//  out      output     out_valid_o / out_ready_i pixel x/y, color, last flag
//
//  one item per clock sustained while out_ready_i stays high; a step reaches
//  out_valid_o through the queue register, then the output register
//  the two-entry queue decouples setup from stepping; in_ready_o drops only
//  when it is full
//  a held result on out stalls the stepper, not the intake, until the queue fills
//  reset clears busy, queue count and output valid
// ----------------------------------------------------------------------------
module line_pixel_generator #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [COORD_BITS-1:0]           start_x_i,
  input  logic [COORD_BITS-1:0]           start_y_i,
  input  logic [COORD_BITS-1:0]           end_x_i,
  input  logic [COORD_BITS-1:0]           end_y_i,
  input  logic [lpg_pkg::COLOR_BITS-1:0]  line_color_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS-1:0]           pixel_x_o,
  output logic [COORD_BITS-1:0]           pixel_y_o,
  output logic [lpg_pkg::COLOR_BITS-1:0]  pixel_color_o,
  output logic                            last_pixel_o
);

  localparam int unsigned EntryBits = 3 + 5 * COORD_BITS + 1 + lpg_pkg::COLOR_BITS;

  logic                           f_is_load, f_transposed, f_minor_down;
  logic [COORD_BITS-1:0]          f_major_pos, f_major_end, f_minor_pos, f_major_span;
  logic [COORD_BITS:0]            f_minor_twice;

  logic                           b_is_load, b_transposed, b_minor_down;
  logic [COORD_BITS-1:0]          b_major_pos, b_major_end, b_minor_pos, b_major_span;
  logic [COORD_BITS:0]            b_minor_twice;
  logic [lpg_pkg::COLOR_BITS-1:0] b_color;

  logic [EntryBits-1:0]           push_data, pop_data;
  logic                           q_full, q_empty, q_pop;

  lpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .command_i    (command_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .is_load_o    (f_is_load),
    .transposed_o (f_transposed),
    .minor_down_o (f_minor_down),
    .major_pos_o  (f_major_pos),
    .major_end_o  (f_major_end),
    .minor_pos_o  (f_minor_pos),
    .major_span_o (f_major_span),
    .minor_twice_o(f_minor_twice)
  );

  assign push_data = {f_is_load, f_transposed, f_minor_down, f_major_pos, f_major_end,
                      f_minor_pos, f_major_span, f_minor_twice, line_color_in_i};

  assign in_ready_o = !q_full;

  lpg_queue #(
    .WIDTH(EntryBits),
    .DEPTH(2)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_data_o (pop_data)
  );

  assign {b_is_load, b_transposed, b_minor_down, b_major_pos, b_major_end,
          b_minor_pos, b_major_span, b_minor_twice, b_color} = pop_data;

  lpg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .is_load_i    (b_is_load),
    .transposed_i (b_transposed),
    .minor_down_i (b_minor_down),
    .major_pos_i  (b_major_pos),
    .major_end_i  (b_major_end),
    .minor_pos_i  (b_minor_pos),
    .major_span_i (b_major_span),
    .minor_twice_i(b_minor_twice),
    .color_i      (b_color),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

### tb/pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_checker
// watches both channels of the line pixel generator, traces every loaded line
// on its own and compares each pixel transfer with the oldest predicted pixel
// ----------------------------------------------------------------------------
module pixel_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                command_i,
  input  logic [COORD_BITS-1:0]               start_x_i,
  input  logic [COORD_BITS-1:0]               start_y_i,
  input  logic [COORD_BITS-1:0]               end_x_i,
  input  logic [COORD_BITS-1:0]               end_y_i,
  input  logic [lpg_pkg::COLOR_BITS-1:0]      line_color_in_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [COORD_BITS-1:0]               pixel_x_i,
  input  logic [COORD_BITS-1:0]               pixel_y_i,
  input  logic [lpg_pkg::COLOR_BITS-1:0]      pixel_color_i,
  input  logic                                last_pixel_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t                         x;
    coord_t                         y;
    logic [lpg_pkg::COLOR_BITS-1:0] color;
    logic                           last;
  } pixel_t;

  pixel_t                         pending_pixels[$];
  logic                           tracing;
  logic                           steep;
  logic                           minor_down;
  coord_t                         major_pos;
  coord_t                         major_end;
  coord_t                         minor_pos;
  coord_t                         major_span;
  logic [COORD_BITS:0]            minor_twice;
  int                             error_acc;
  logic [lpg_pkg::COLOR_BITS-1:0] held_color;
  int unsigned                    fails;

  function automatic coord_t coord_dist(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coord_t a0, b0, a1, b1;
    pixel_t px;
    pixel_t want;
    if (!rst_ni) begin
      pending_pixels.delete();
      tracing      = 1'b0;
      steep        = 1'b0;
      minor_down   = 1'b0;
      major_pos    = '0;
      major_end    = '0;
      minor_pos    = '0;
      major_span   = '0;
      minor_twice  = '0;
      error_acc    = 0;
      held_color   = '0;
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (command_i == lpg_pkg::CMD_LOAD) begin
          steep = coord_dist(start_x_i, end_x_i) < coord_dist(start_y_i, end_y_i);
          if (steep) begin
            a0 = start_y_i; b0 = start_x_i; a1 = end_y_i; b1 = end_x_i;
          end else begin
            a0 = start_x_i; b0 = start_y_i; a1 = end_x_i; b1 = end_y_i;
          end
          // order endpoints so the major coordinate counts up
          if (a0 > a1) begin
            {a0, a1} = {a1, a0};
            {b0, b1} = {b1, b0};
          end
          major_pos   = a0;
          major_end   = a1;
          minor_pos   = b0;
          major_span  = a1 - a0;
          minor_twice = {coord_dist(b0, b1), 1'b0};
          minor_down  = b1 < b0;
          error_acc   = 0;
          held_color  = line_color_in_i;
          tracing     = 1'b1;
        end else if (tracing) begin
          px.x     = steep ? minor_pos : major_pos;
          px.y     = steep ? major_pos : minor_pos;
          px.color = held_color;
          px.last  = (major_pos == major_end);
          pending_pixels.push_back(px);
          if (px.last) begin
            tracing = 1'b0;
          end else begin
            major_pos = major_pos + 1'b1;
            error_acc = error_acc + int'(minor_twice);
            if (error_acc > int'(major_span)) begin
              minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
              error_acc = error_acc - 2 * int'(major_span);
            end
          end
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel transfer with none expected: x %0d y %0d", pixel_x_i, pixel_y_i);
          fails++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_x_i !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, pixel_x_i);
            fails++;
          end
          if (pixel_y_i !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, pixel_y_i);
            fails++;
          end
          if (pixel_color_i !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, pixel_color_i);
            fails++;
          end
          if (last_pixel_i !== want.last) begin
            $error("last_pixel: expected %b, got %b", want.last, last_pixel_i);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= unsigned'(pending_pixels.size());
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives load and step commands into the line pixel generator: corner lines,
// random lines, broken lines, stray steps, a steep full-range line; random
// gaps on both channels, one long output stall; the checker judges pixels
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned RAND_ITEMS  = 600;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN       = 20;
  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned WIDE_STEPS  = 32;

  typedef logic [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = '1;

  logic                           clk_i;
  logic                           rst_ni          = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_ready;
  logic                           command         = lpg_pkg::CMD_LOAD;
  coord_t                         start_x         = '0;
  coord_t                         start_y         = '0;
  coord_t                         end_x           = '0;
  coord_t                         end_y           = '0;
  logic [lpg_pkg::COLOR_BITS-1:0] line_color      = '0;
  logic                           out_valid;
  logic                           out_ready       = 1'b0;
  coord_t                         pixel_x;
  coord_t                         pixel_y;
  logic [lpg_pkg::COLOR_BITS-1:0] pixel_color;
  logic                           last_pixel;
  int unsigned                    fail_count;
  int unsigned                    pixels_pending;
  bit                             in_idle_en      = 1'b1;
  bit                             out_idle_en     = 1'b1;
  bit                             hold_req        = 1'b0;
  int unsigned                    cycle_cnt       = 0;

  line_pixel_generator #(
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (command),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .end_x_i         (end_x),
    .end_y_i         (end_y),
    .line_color_in_i (line_color),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .pixel_color_o   (pixel_color),
    .last_pixel_o    (last_pixel)
  );

  pixel_checker #(
    .COORD_BITS (COORD_BITS)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .command_i       (command),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .end_x_i         (end_x),
    .end_y_i         (end_y),
    .line_color_in_i (line_color),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_x_i       (pixel_x),
    .pixel_y_i       (pixel_y),
    .pixel_color_i   (pixel_color),
    .last_pixel_i    (last_pixel),
    .fail_count_o    (fail_count),
    .pending_o       (pixels_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one transfer on the input channel, after a random gap
  task automatic send_item(input logic cmd, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic [lpg_pkg::COLOR_BITS-1:0] color);
    int unsigned gap;
    gap = in_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    start_x    <= sx;
    start_y    <= sy;
    end_x      <= ex;
    end_y      <= ey;
    line_color <= color;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic load_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input logic [lpg_pkg::COLOR_BITS-1:0] color);
    send_item(lpg_pkg::CMD_LOAD, sx, sy, ex, ey, color);
  endtask

  // step payload is don't-care, so it is random
  task automatic step_n(input int unsigned n);
    repeat (n) send_item(lpg_pkg::CMD_STEP, coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom), $urandom);
  endtask

  function automatic coord_t near_coord(coord_t base, int unsigned reach);
    int d;
    d = $urandom_range(0, reach);
    if ((($urandom_range(0, 1) == 1) && int'(base) >= d) || int'(base) + d > int'(COORD_MAX))
      return base - coord_t'(d);
    return base + coord_t'(d);
  endfunction

  function automatic int unsigned pixel_count(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int dx, dy;
    dx = int'(sx) - int'(ex);
    dy = int'(sy) - int'(ey);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = out_idle_en ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned kind;
    int unsigned n;
    int unsigned reach;
    coord_t sx, sy, ex, ey;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner lines
    step_n(1);
    load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1);
    step_n(2);
    load_line(coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(3), '0);
    step_n(4);
    load_line(coord_t'(5), coord_t'(0), coord_t'(0), coord_t'(2), 32'h1234_5678);
    step_n(6);
    load_line(coord_t'(10), coord_t'(20), coord_t'(8), coord_t'(13), 32'h0f0f_0f0f);
    step_n(2);
    load_line(coord_t'(0), COORD_MAX, COORD_MAX, coord_t'(0), 32'ha5a5_a5a5);
    step_n(2);
    load_line(COORD_MAX, coord_t'(0), COORD_MAX - coord_t'(2), coord_t'(3), 32'h5a5a_5a5a);
    step_n(4);

    // long stall on the output while a line keeps stepping
    hold_req = 1'b1;
    load_line(coord_t'(100), coord_t'(100), coord_t'(140), coord_t'(117), $urandom);
    step_n(41);
    items_sent = 69;

    while (items_sent < RAND_ITEMS) begin
      kind        = $urandom_range(0, 9);
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      if (kind < 7) begin
        reach = (($urandom_range(0, 15) == 0) && (items_sent + 210 < RAND_ITEMS)) ? 200 : 24;
        ex = near_coord(sx, reach);
        ey = near_coord(sy, reach);
        n  = pixel_count(sx, sy, ex, ey);
        load_line(sx, sy, ex, ey, $urandom);
        step_n(n);
        items_sent += 1 + n;
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 2);
          step_n(n);
          items_sent += n;
        end
      end else if (kind < 9) begin
        // line dropped part way by the next load
        if (kind == 7) begin
          ex = coord_t'($urandom);
          ey = coord_t'($urandom);
        end else begin
          ex = near_coord(sx, 24);
          ey = near_coord(sy, 24);
        end
        n = $urandom_range(0, pixel_count(sx, sy, ex, ey) - 1);
        if (n > 6) n = 6;
        load_line(sx, sy, ex, ey, $urandom);
        step_n(n);
        items_sent += 1 + n;
      end else begin
        n = $urandom_range(1, 3);
        step_n(n);
        items_sent += n;
      end
    end

    // one steep line over the full coordinate range, stepped part way
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    sx = coord_t'($urandom);
    ex = coord_t'($urandom);
    load_line(sx, coord_t'(0), ex, COORD_MAX, $urandom);
    step_n(WIDE_STEPS);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (fail_count == 0 && pixels_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
sv/lpg_pkg.sv
sv/lpg_queue.sv
sv/lpg_front.sv
sv/lpg_back.sv
sv/line_pixel_generator.sv
tb/pixel_checker.sv
tb/tb_top.sv
